// ----- rtl/core/bmmd_pkg.sv -----
`default_nettype none
package bmmd_pkg;

  // field and register widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SCNT_W   = 17;
  localparam int unsigned BCNT_W   = 13;
  localparam int unsigned BIDX_W   = 12;
  localparam int unsigned SUM_W    = 49;
  localparam int unsigned CFG_W    = 17;

  localparam logic [SCNT_W-1:0] MAX_SAMPLES = SCNT_W'(65536);
  localparam logic [BCNT_W-1:0] MAX_BUCKETS = BCNT_W'(4096);

  // shared divider: unsigned, one quotient bit per cycle
  localparam int unsigned DVD_W      = 48;
  localparam int unsigned DVS_W      = 17;
  localparam int unsigned DIV_STEPS  = DVD_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // config register indexes
  localparam logic CFG_SAMPLE_COUNT = 1'b0;
  localparam logic CFG_BUCKET_COUNT = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/bmmd_div.sv -----
`default_nettype none
module bmmd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmmd_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic [bmmd_pkg::DVD_W-1:0] quot_o
);
  import bmmd_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  // restoring step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        quo_q <= {quo_q[DVD_W-2:0], ge};
        rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// ----- rtl/core/bucket_min_max_decimator.sv -----
// Bucket min/max decimator.
// Input channel: one sample beat (key, value, missing flag) per accepted
// in_valid_i with in_stall_o low. Output channel: one bucket beat on
// out_valid_o, taken when out_stall_i is low.
// Config: cfg_we_i writes sample_count (index 0) or bucket_count (index 1);
// any write restarts the window. Write only while the block is idle.
// A window of sample_count samples is cut into bucket_count near-equal
// buckets; each bucket end gives mean key, min and max value, or an empty flag.
// Steps: a sample that does not close a bucket goes from idle to check and
// back to idle. The first sample of each bucket also waits for the bucket end
// index (n*(b+1)/B on the shared 48-step restoring divider). A bucket end with
// valid samples then waits for the mean key division on the same divider; an
// empty bucket end goes straight to the emit state. in_stall_o is high for
// the whole of that work.
// The result sits in an output register, so the block takes new samples while
// a bucket beat waits; a second bucket end stalls until the first is taken.
// Reset: sample_count = bucket_count = 1, window and bucket state cleared.
`default_nettype none
module bucket_min_max_decimator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [bmmd_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [bmmd_pkg::SAMPLE_W-1:0] sample_key_i,
  input  logic signed [bmmd_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                            sample_missing_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [bmmd_pkg::SAMPLE_W-1:0] center_key_o,
  output logic signed [bmmd_pkg::SAMPLE_W-1:0] bucket_min_o,
  output logic signed [bmmd_pkg::SAMPLE_W-1:0] bucket_max_o,
  output logic                            bucket_empty_o,
  output logic                            last_bucket_o
);
  import bmmd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BND,
    S_CHECK,
    S_MEAN,
    S_EMIT
  } state_e;

  localparam logic signed [SAMPLE_W-1:0] VAL_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] VAL_NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

  state_e state_q;

  // config
  logic [SCNT_W-1:0] sample_count_q;
  logic [BCNT_W-1:0] bucket_count_q;

  // window / bucket state
  logic [SCNT_W-1:0]          sample_index_q;
  logic [SCNT_W-1:0]          pos_q;
  logic [BIDX_W-1:0]          bucket_index_q;
  logic [SCNT_W-1:0]          boundary_q;
  logic                       bnd_valid_q;
  logic signed [SAMPLE_W-1:0] running_min_q;
  logic signed [SAMPLE_W-1:0] running_max_q;
  logic [SUM_W-1:0]           key_sum_q;
  logic [SCNT_W-1:0]          valid_samples_q;
  logic                       last_q;
  logic                       neg_q;
  logic [SAMPLE_W-1:0]        res_key_q;
  logic                       res_empty_q;

  // output register
  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_key_q;
  logic [SAMPLE_W-1:0]        out_min_q;
  logic [SAMPLE_W-1:0]        out_max_q;
  logic                       out_empty_q;
  logic                       out_last_q;

  // divider
  div_req_t         div_req_q;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;

  // effective counts
  logic [SCNT_W-1:0] eff_n;
  logic [BCNT_W-1:0] b_lim;
  logic [BCNT_W-1:0] eff_b;
  logic [BCNT_W-1:0] bkt_next;
  logic [SCNT_W+BCNT_W-1:0] bnd_prod;
  logic [SUM_W-1:0]  sum_mag;
  logic [SAMPLE_W-1:0] quot_lo;
  logic              at_bucket_end;
  logic              is_last;
  logic              emit_fire;
  logic              div_start;

  assign eff_n = (sample_count_q == '0) ? SCNT_W'(1) :
                 (sample_count_q > MAX_SAMPLES) ? MAX_SAMPLES : sample_count_q;
  assign b_lim = (bucket_count_q == '0) ? BCNT_W'(1) :
                 (bucket_count_q > MAX_BUCKETS) ? MAX_BUCKETS : bucket_count_q;
  assign eff_b = ({{(SCNT_W-BCNT_W){1'b0}}, b_lim} > eff_n) ? eff_n[BCNT_W-1:0] : b_lim;

  assign bkt_next = {1'b0, bucket_index_q} + BCNT_W'(1);
  // end index of the current bucket is n*(b+1)/B
  assign bnd_prod = eff_n * bkt_next;

  assign sum_mag = key_sum_q[SUM_W-1] ? (SUM_W'(0) - key_sum_q) : key_sum_q;
  assign quot_lo = div_quot[SAMPLE_W-1:0];

  assign at_bucket_end = !((pos_q < boundary_q) && (pos_q < eff_n));
  assign is_last       = (bkt_next >= eff_b) || (pos_q >= eff_n);

  // bucket beat moves into the output register
  assign emit_fire = !cfg_we_i && (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // divider kick: bucket end index on a bucket's first sample, mean at its end
  assign div_start = !cfg_we_i &&
                     (((state_q == S_IDLE) && in_valid_i && !bnd_valid_q) ||
                      ((state_q == S_CHECK) && at_bucket_end &&
                       (valid_samples_q != '0)));

  bmmd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      sample_count_q  <= SCNT_W'(1);
      bucket_count_q  <= BCNT_W'(1);
      sample_index_q  <= '0;
      pos_q           <= '0;
      bucket_index_q  <= '0;
      boundary_q      <= '0;
      bnd_valid_q     <= 1'b0;
      running_min_q   <= VAL_POS_MAX;
      running_max_q   <= VAL_NEG_MAX;
      key_sum_q       <= '0;
      valid_samples_q <= '0;
      last_q          <= 1'b0;
      neg_q           <= 1'b0;
      res_key_q       <= '0;
      res_empty_q     <= 1'b0;
      out_valid_q     <= 1'b0;
      div_req_q       <= '0;
    end else begin
      div_req_q.start <= div_start;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[SCNT_W-1:0];
          CFG_BUCKET_COUNT: bucket_count_q <= cfg_data_i[BCNT_W-1:0];
          default: ;
        endcase
        // restart the window
        sample_index_q  <= '0;
        bucket_index_q  <= '0;
        boundary_q      <= '0;
        bnd_valid_q     <= 1'b0;
        running_min_q   <= VAL_POS_MAX;
        running_max_q   <= VAL_NEG_MAX;
        key_sum_q       <= '0;
        valid_samples_q <= '0;
        state_q         <= S_IDLE;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (in_valid_i) begin
              if (!sample_missing_i) begin
                if (sample_value_i < running_min_q) running_min_q <= sample_value_i;
                if (sample_value_i > running_max_q) running_max_q <= sample_value_i;
                key_sum_q <= key_sum_q +
                             {{(SUM_W-SAMPLE_W){sample_key_i[SAMPLE_W-1]}}, sample_key_i};
                valid_samples_q <= valid_samples_q + 1'b1;
              end
              pos_q <= sample_index_q + 1'b1;
              if (bnd_valid_q) begin
                state_q <= S_CHECK;
              end else begin
                div_req_q.dividend <= {{(DVD_W-SCNT_W-BCNT_W){1'b0}}, bnd_prod};
                div_req_q.divisor  <= {{(DVS_W-BCNT_W){1'b0}}, eff_b};
                state_q            <= S_BND;
              end
            end
          end
          S_BND: begin
            if (div_done) begin
              boundary_q  <= div_quot[SCNT_W-1:0];
              bnd_valid_q <= 1'b1;
              state_q     <= S_CHECK;
            end
          end
          S_CHECK: begin
            if (!at_bucket_end) begin
              sample_index_q <= pos_q;
              state_q        <= S_IDLE;
            end else begin
              last_q <= is_last;
              if (valid_samples_q == '0) begin
                res_key_q   <= '0;
                res_empty_q <= 1'b1;
                state_q     <= S_EMIT;
              end else begin
                neg_q              <= key_sum_q[SUM_W-1];
                div_req_q.dividend <= sum_mag[DVD_W-1:0];
                div_req_q.divisor  <= valid_samples_q;
                state_q            <= S_MEAN;
              end
            end
          end
          S_MEAN: begin
            if (div_done) begin
              // truncate toward zero: divide the magnitude, restore the sign
              res_key_q   <= neg_q ? (SAMPLE_W'(0) - quot_lo) : quot_lo;
              res_empty_q <= 1'b0;
              state_q     <= S_EMIT;
            end
          end
          S_EMIT: begin
            if (!out_valid_q || !out_stall_i) begin
              out_key_q   <= res_key_q;
              out_min_q   <= res_empty_q ? '0 : running_min_q;
              out_max_q   <= res_empty_q ? '0 : running_max_q;
              out_empty_q <= res_empty_q;
              out_last_q  <= last_q;
              running_min_q   <= VAL_POS_MAX;
              running_max_q   <= VAL_NEG_MAX;
              key_sum_q       <= '0;
              valid_samples_q <= '0;
              bnd_valid_q     <= 1'b0;
              if (last_q) begin
                sample_index_q <= '0;
                bucket_index_q <= '0;
                boundary_q     <= '0;
              end else begin
                sample_index_q <= pos_q;
                bucket_index_q <= bucket_index_q + 1'b1;
              end
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign in_stall_o     = (state_q != S_IDLE) || cfg_we_i;
  assign out_valid_o    = out_valid_q;
  assign center_key_o   = out_key_q;
  assign bucket_min_o   = out_min_q;
  assign bucket_max_o   = out_max_q;
  assign bucket_empty_o = out_empty_q;
  assign last_bucket_o  = out_last_q;

  // a waiting sample always lies before the end of its bucket
  a_bnd_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && bnd_valid_q) |-> (sample_index_q < boundary_q))
    else $error("bucket end index not ahead of sample index");

  // valid count never exceeds the samples seen in the window
  a_valid_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (valid_samples_q <= sample_index_q))
    else $error("valid sample count too large");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bucket_empty_o) |->
      (center_key_o == '0 && bucket_min_o == '0 && bucket_max_o == '0))
    else $error("empty bucket with nonzero fields");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !bucket_empty_o) |-> (bucket_min_o <= bucket_max_o))
    else $error("bucket min above max");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmmd_pkg::*;

  // run shape
  localparam int unsigned RAND_ITEMS   = 1300;
  localparam int unsigned QUIET_CYCLES = 150;       // > index div + mean div + output reg
  localparam int unsigned LIMIT_NS     = 4_000_000; // hang guard limit in ns, with a 4 ns clock
  localparam int unsigned MAX_REPORTS  = 10;

  // idle mix: who backs off how often (percent of cycles)
  typedef enum logic [1:0] {
    PACE_RX_HEAVY,  // sender idles 26, receiver stalls 74
    PACE_TX_HEAVY,  // sender idles 74, receiver stalls 26
    PACE_FREE       // no idling at all
  } pace_e;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] center;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic                       empty;
    logic                       last;
  } bucket_res_t;

  // one line of the directed plan: either a register write or a sample beat
  typedef struct packed {
    row_kind_e                  kind;
    logic                       cfg_idx;
    logic [CFG_W-1:0]           cfg_val;
    logic signed [SAMPLE_W-1:0] key;
    logic signed [SAMPLE_W-1:0] value;
    logic                       miss;
    logic                       typed;   // want below is hand-written
    bucket_res_t                want;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time 0
  // ---------------------------------------------------------------------------
  logic                       clk_i            = 1'b0;
  logic                       rst_ni           = 1'b0;
  logic                       cfg_we_i         = 1'b0;
  logic                       cfg_index_i      = CFG_SAMPLE_COUNT;
  logic [CFG_W-1:0]           cfg_data_i       = '0;
  logic                       in_valid_i       = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_key_i     = '0;
  logic signed [SAMPLE_W-1:0] sample_value_i   = '0;
  logic                       sample_missing_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i      = 1'b1;
  logic signed [SAMPLE_W-1:0] center_key_o;
  logic signed [SAMPLE_W-1:0] bucket_min_o;
  logic signed [SAMPLE_W-1:0] bucket_max_o;
  logic                       bucket_empty_o;
  logic                       last_bucket_o;

  bucket_min_max_decimator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_key_i    (sample_key_i),
    .sample_value_i  (sample_value_i),
    .sample_missing_i(sample_missing_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .center_key_o    (center_key_o),
    .bucket_min_o    (bucket_min_o),
    .bucket_max_o    (bucket_max_o),
    .bucket_empty_o  (bucket_empty_o),
    .last_bucket_o   (last_bucket_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bucket predictor: own copy of config and window/bucket state
  // ---------------------------------------------------------------------------
  logic [SCNT_W-1:0]          win_len_reg   = SCNT_W'(1);
  logic [BCNT_W-1:0]          bkt_cnt_reg   = BCNT_W'(1);
  int unsigned                win_pos;      // samples taken in this window
  int unsigned                bkt_idx;      // bucket being filled
  logic signed [SAMPLE_W-1:0] lo_val;
  logic signed [SAMPLE_W-1:0] hi_val;
  longint                     key_acc;      // wide enough for 64k full-scale keys
  int unsigned                kept;         // non-missing samples in bucket

  bucket_res_t bucket_expect[$];            // predicted bucket beats, oldest first

  pace_e       pace = PACE_RX_HEAVY;
  int unsigned errors;
  int unsigned samples_sent;
  int unsigned settings_done;
  int unsigned beats_checked;
  int unsigned empty_seen;
  int unsigned last_seen;

  function automatic void clear_bucket();
    lo_val  = 32'sh7fff_ffff;
    hi_val  = 32'sh8000_0000;
    key_acc = 0;
    kept    = 0;
  endfunction

  function automatic void clear_window();
    win_pos = 0;
    bkt_idx = 0;
    clear_bucket();
  endfunction

  // any register write restarts the window
  function automatic void apply_reg(input logic idx, input logic [CFG_W-1:0] val);
    if (idx == CFG_SAMPLE_COUNT) win_len_reg = val[SCNT_W-1:0];
    else                         bkt_cnt_reg = val[BCNT_W-1:0];
    clear_window();
  endfunction

  // Takes one accepted sample; returns 1 with the bucket beat when it closes one.
  function automatic bit predict_bucket(input logic signed [SAMPLE_W-1:0] key,
                                        input logic signed [SAMPLE_W-1:0] value,
                                        input logic miss, output bucket_res_t res);
    int unsigned n;
    int unsigned b;
    int unsigned pos;
    int unsigned bound;
    bit          last;
    // zero means one; too large saturates; buckets never outnumber samples
    n = (win_len_reg == 0) ? 1 : int'(win_len_reg);
    if (n > int'(MAX_SAMPLES)) n = int'(MAX_SAMPLES);
    b = (bkt_cnt_reg == 0) ? 1 : int'(bkt_cnt_reg);
    if (b > int'(MAX_BUCKETS)) b = int'(MAX_BUCKETS);
    if (b > n) b = n;
    pos = win_pos + 1;
    res = '0;
    if (!miss) begin
      if (value < lo_val) lo_val = value;
      if (value > hi_val) hi_val = value;
      key_acc += longint'(key);
      kept++;
    end
    bound = (n * (bkt_idx + 1)) / b;
    if (bound > n) bound = n;
    if (pos < bound && pos < n) begin
      win_pos = pos;
      return 1'b0;
    end
    last = (bkt_idx + 1 >= b) || (pos >= n);
    if (kept != 0) begin
      // signed longint division truncates toward zero
      res.center = SAMPLE_W'(key_acc / longint'(kept));
      res.lo     = lo_val;
      res.hi     = hi_val;
    end
    res.empty = (kept == 0);
    res.last  = last;
    if (last) begin
      clear_window();
    end else begin
      clear_bucket();
      bkt_idx++;
      win_pos = pos;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: check each taken bucket beat, then pick next cycle's stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bucket_res_t got;
    bucket_res_t want;
    bit          bad;
    int unsigned stall_pct;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {center_key_o, bucket_min_o, bucket_max_o, bucket_empty_o, last_bucket_o};
      if (bucket_expect.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected bucket beat: key %0d min %0d max %0d empty %0b last %0b",
                   $realtime, got.center, got.lo, got.hi, got.empty, got.last);
      end else begin
        want = bucket_expect.pop_front();
        beats_checked++;
        if (want.empty) empty_seen++;
        if (want.last)  last_seen++;
        bad = (got.center !== want.center) || (got.lo !== want.lo) ||
              (got.hi !== want.hi) || (got.empty !== want.empty) ||
              (got.last !== want.last);
        if (bad) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("[%0t] bucket %0d mismatch", $realtime, beats_checked);
            $display("  exp: key %0d min %0d max %0d empty %0b last %0b",
                     want.center, want.lo, want.hi, want.empty, want.last);
            $display("  got: key %0d min %0d max %0d empty %0b last %0b",
                     got.center, got.lo, got.hi, got.empty, got.last);
          end
        end
      end
    end
    case (pace)
      PACE_RX_HEAVY: stall_pct = 74;
      PACE_TX_HEAVY: stall_pct = 26;
      default:       stall_pct = 0;
    endcase
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Drop valid and wait until every predicted beat has been taken.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bucket_expect.size() != 0) @(posedge clk_i);
  endtask

  // Register write: only with the block idle. A sample that closes no bucket
  // can still have the divider busy, hence the quiet stretch after draining.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    hold_until_drained();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
    cfg_we_i    <= 1'b0;
  endtask

  // One sample beat, with a random gap in front. Valid is only lowered when
  // at least one idle cycle follows, so back-to-back beats keep it high.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] key,
                             input logic signed [SAMPLE_W-1:0] value,
                             input logic miss, input logic typed,
                             input bucket_res_t typed_res);
    int unsigned gap_pct;
    bucket_res_t res;
    case (pace)
      PACE_RX_HEAVY: gap_pct = 26;
      PACE_TX_HEAVY: gap_pct = 74;
      default:       gap_pct = 0;
    endcase
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i       <= 1'b1;
    sample_key_i     <= key;
    sample_value_i   <= value;
    sample_missing_i <= miss;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
    if (predict_bucket(key, value, miss, res))
      bucket_expect.push_back(typed ? typed_res : res);
  endtask

  // full-scale words, small signed values around zero, and plain random
  function automatic logic [SAMPLE_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return SAMPLE_W'($urandom_range(20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // directed plan builders
  function automatic plan_row_t reg_row(input logic idx, input logic [CFG_W-1:0] val);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic plan_row_t sample_row(input logic signed [SAMPLE_W-1:0] key,
                                           input logic signed [SAMPLE_W-1:0] value,
                                           input logic miss);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_SAMPLE;
    r.key   = key;
    r.value = value;
    r.miss  = miss;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic signed [SAMPLE_W-1:0] key,
                                            input logic signed [SAMPLE_W-1:0] value,
                                            input logic miss,
                                            input logic signed [SAMPLE_W-1:0] center,
                                            input logic signed [SAMPLE_W-1:0] lo,
                                            input logic signed [SAMPLE_W-1:0] hi,
                                            input logic empty, input logic last);
    plan_row_t r;
    r       = sample_row(key, value, miss);
    r.typed = 1'b1;
    r.want  = {center, lo, hi, empty, last};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t        plan[$];
    int unsigned      rand_items;
    int unsigned      scnt;
    int unsigned      bcnt;
    int unsigned      len;
    int unsigned      miss_pct;
    logic [CFG_W-1:0] bval;

    clear_window();
    rand_items = 0;

    // after reset: one sample per window, one bucket, every beat is last
    plan.push_back(checked_row(0, 0, 0, 0, 0, 0, 0, 1));
    plan.push_back(checked_row(32'h7fffffff, 32'h7fffffff, 0,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1));
    plan.push_back(checked_row(32'h80000000, 32'h80000000, 0,
                               32'h80000000, 32'h80000000, 32'h80000000, 0, 1));
    plan.push_back(checked_row(32'h7fffffff, 32'h80000000, 0,
                               32'h7fffffff, 32'h80000000, 32'h80000000, 0, 1));
    plan.push_back(checked_row(-1, 1, 0, -1, 1, 1, 0, 1));
    // missing sample: empty bucket, fields zero
    plan.push_back(checked_row(-1, 32'h7fffffff, 1, 0, 0, 0, 1, 1));
    // zero sample count behaves as one
    plan.push_back(reg_row(CFG_SAMPLE_COUNT, 0));
    plan.push_back(checked_row(5, -5, 0, 5, -5, -5, 0, 1));
    // zero bucket count behaves as one
    plan.push_back(reg_row(CFG_BUCKET_COUNT, 0));
    plan.push_back(checked_row(7, 7, 1, 0, 0, 0, 1, 1));
    // 4 samples / 2 buckets: negative mean truncates, all-missing bucket,
    // then a second window with full-scale keys
    plan.push_back(reg_row(CFG_SAMPLE_COUNT, 4));
    plan.push_back(reg_row(CFG_BUCKET_COUNT, 2));
    plan.push_back(sample_row(-3, 10, 0));
    plan.push_back(sample_row(-4, -20, 0));
    plan.push_back(sample_row(9, 9, 1));
    plan.push_back(sample_row(-9, -9, 1));
    plan.push_back(sample_row(32'h7fffffff, 1, 0));
    plan.push_back(sample_row(32'h7fffffff, 2, 0));
    plan.push_back(sample_row(32'h80000000, 32'h7fffffff, 0));
    plan.push_back(sample_row(0, 0, 1));
    // more buckets asked than samples: clamped to the sample count
    plan.push_back(reg_row(CFG_SAMPLE_COUNT, 3));
    plan.push_back(reg_row(CFG_BUCKET_COUNT, 8191));
    plan.push_back(sample_row(1, 1, 0));
    plan.push_back(sample_row(2, 2, 1));
    plan.push_back(sample_row(-2, 7, 0));
    // uneven split 5/3; data bits above the bucket field are dropped
    plan.push_back(reg_row(CFG_SAMPLE_COUNT, 5));
    plan.push_back(reg_row(CFG_BUCKET_COUNT, 17'h1_e003));
    plan.push_back(sample_row(10, -1, 0));
    plan.push_back(sample_row(11, -2, 0));
    plan.push_back(sample_row(-12, 3, 0));
    plan.push_back(sample_row(13, -4, 1));
    plan.push_back(sample_row(-14, 5, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_sample(plan[i].key, plan[i].value, plan[i].miss, plan[i].typed, plan[i].want);
      end
    end

    // random phases: new setting, then a few windows' worth of samples
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin                // short windows, any split
          scnt = $urandom_range(40, 1);
          bcnt = $urandom_range(scnt + 3, 1);
          len  = $urandom_range(3 * scnt, scnt);
        end
        5: begin                            // bucket count zero or saturated
          scnt = $urandom_range(20, 1);
          bcnt = $urandom_range(1) ? 0 : 8191;
          len  = $urandom_range(2 * scnt, scnt) + 1;
        end
        6: begin                            // single-sample windows
          scnt = $urandom_range(1);
          bcnt = $urandom_range(8191);
          len  = 10;
        end
        7: begin                            // largest window, most buckets
          scnt = $urandom_range(1) ? 65536 : $urandom_range(131071, 65537);
          bcnt = $urandom_range(1) ? 4096 : $urandom_range(8191, 4097);
          len  = 48;
        end
        8: begin                            // big window, buckets of 1..16
          scnt = $urandom_range(65536, 4097);
          bcnt = 4096;
          len  = 40;
        end
        default: begin                      // medium windows, wide buckets
          scnt = $urandom_range(300, 41);
          bcnt = $urandom_range(scnt / 4 + 1, 1);
          len  = $urandom_range(scnt + 20, scnt / 2);
        end
      endcase
      case ($urandom_range(3))
        0:       miss_pct = 0;
        1:       miss_pct = 10;
        2:       miss_pct = 50;
        default: miss_pct = 95;             // mostly empty buckets
      endcase
      // random junk above the 13-bit bucket field
      bval = {4'($urandom_range(15)), 13'(bcnt)};
      write_reg(CFG_SAMPLE_COUNT, CFG_W'(scnt));
      write_reg(CFG_BUCKET_COUNT, bval);
      settings_done++;
      for (int unsigned i = 0; i < len && rand_items < RAND_ITEMS; i++) begin
        if (rand_items < RAND_ITEMS / 3)          pace = PACE_RX_HEAVY;
        else if (rand_items < 2 * RAND_ITEMS / 3) pace = PACE_TX_HEAVY;
        else                                      pace = PACE_FREE;
        // now and then let the output side run dry mid-window
        if ((rand_items % 250) == 125 || $urandom_range(199) == 0)
          hold_until_drained();
        send_sample(pick_word(), pick_word(), ($urandom_range(99) < miss_pct), 1'b0, '0);
        rand_items++;
      end
    end

    // drain, then give the block time to show any stray beat
    hold_until_drained();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (bucket_expect.size() != 0) begin
      errors += bucket_expect.size();
      $display("%0d predicted bucket beats never arrived", bucket_expect.size());
    end

    $display("Sent %0d samples over %0d random settings; %0d bucket beats checked",
             samples_sent, settings_done, beats_checked);
    $display("(%0d empty buckets, %0d window ends, %0d mismatches)",
             empty_seen, last_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_NS);
    $display("Timeout: %0d bucket beats still pending", bucket_expect.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
